>>> rtl/csp_pkg.sv
// Shared constants and types for the contrast stretch pixel block.
package csp_pkg;

  localparam int PIXEL_BITS_DEF = 8;
  localparam int OFFSET_W       = 9;
  localparam int FIFO_DEPTH     = 2;
  localparam int KIND_W         = 2;

  // How the back end finishes an apply request.
  typedef enum logic [KIND_W-1:0] {
    KIND_ZERO = 2'd0,
    KIND_FULL = 2'd1,
    KIND_DIV  = 2'd2
  } kind_e;

endpackage

>>> rtl/csp_front.sv
// Front end: takes requests, keeps frame statistics and classifies apply requests.
module csp_front #(
  parameter int PIXEL_BITS = csp_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [csp_pkg::OFFSET_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic                         first_pixel_i,
  input  logic [PIXEL_BITS-1:0]        red_i,
  input  logic [PIXEL_BITS-1:0]        green_i,
  input  logic [PIXEL_BITS-1:0]        blue_i,
  input  logic                         fifo_full_i,
  output logic                         push_o,
  output logic [csp_pkg::KIND_W-1:0]   kind_o,
  output logic [2*PIXEL_BITS-1:0]      num_o,
  output logic [PIXEL_BITS-1:0]        den_o
);
  import csp_pkg::*;

  localparam int P  = PIXEL_BITS;
  localparam int SW = ((P > OFFSET_W) ? P : OFFSET_W) + 2;
  localparam logic [P-1:0] MAXV = {P{1'b1}};
  localparam logic signed [SW-1:0] MAXV_E = {{(SW-P){1'b0}}, MAXV};

  logic [P-1:0]          min_q, min_d, max_q, max_d;
  logic [OFFSET_W-1:0]   offset_q;
  logic [P-1:0]          rg, v;
  logic                  accept;
  logic signed [SW-1:0]  mn_e, mx_e, off_e, v_e;
  logic signed [SW-1:0]  lo_t, hi_t, lo, hi, diff, den;
  logic [SW-1:0]         a_abs, d_abs;
  logic [P-1:0]          a_p, d_p;
  kind_e                 kind;

  assign rg = (red_i > green_i) ? red_i : green_i;
  assign v  = (rg > blue_i) ? rg : blue_i;

  assign in_ready_o = ~fifo_full_i | ~operation_i;
  assign accept     = in_valid_i & in_ready_o;
  assign push_o     = accept & operation_i;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (accept && !operation_i) begin
      if (first_pixel_i) begin
        min_d = v;
        max_d = v;
      end else begin
        if (v < min_q) min_d = v;
        if (v > max_q) max_d = v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= MAXV;
      max_q    <= '0;
      offset_q <= '0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
      if (cfg_we_i) offset_q <= cfg_wdata_i;
    end
  end

  assign mn_e  = {{(SW-P){1'b0}}, min_q};
  assign mx_e  = {{(SW-P){1'b0}}, max_q};
  assign v_e   = {{(SW-P){1'b0}}, v};
  assign off_e = {{(SW-OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};

  // A positive offset widens the range with clamping; a negative one moves both ends up, unclamped.
  always_comb begin
    lo_t = mn_e - off_e;
    if (off_e > 0) begin
      hi_t = mx_e + off_e;
      lo   = (lo_t < 0) ? '0 : lo_t;
      hi   = (hi_t > MAXV_E) ? MAXV_E : hi_t;
    end else begin
      hi_t = mx_e - off_e;
      lo   = lo_t;
      hi   = hi_t;
    end
  end

  assign diff  = v_e - lo;
  assign den   = hi - lo;
  assign a_abs = diff[SW-1] ? SW'(-diff) : SW'(diff);
  assign d_abs = den[SW-1] ? SW'(-den) : SW'(den);
  assign a_p   = a_abs[P-1:0];
  assign d_p   = d_abs[P-1:0];

  // With matching signs the quotient is |diff|*MAXV/|den|; other signs clamp to zero.
  always_comb begin
    if (den == 0) begin
      kind = (diff > 0) ? KIND_FULL : KIND_ZERO;
    end else if (diff == 0 || (diff[SW-1] != den[SW-1])) begin
      kind = KIND_ZERO;
    end else if (a_abs >= d_abs) begin
      kind = KIND_FULL;
    end else begin
      kind = KIND_DIV;
    end
  end

  assign kind_o = kind;
  assign num_o  = {a_p, {P{1'b0}}} - {{P{1'b0}}, a_p};
  assign den_o  = d_p;

endmodule

>>> rtl/csp_fifo.sv
// Short queue between the front end and the back end.
module csp_fifo #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] pop_data_o
);
  import csp_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [DW-1:0] mem_q [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o     = (count_q == CW'(FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

>>> rtl/csp_back.sv
// Back end: serial divider, clamping and the output register.
module csp_back #(
  parameter int PIXEL_BITS = csp_pkg::PIXEL_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       entry_valid_i,
  input  logic [csp_pkg::KIND_W-1:0] kind_i,
  input  logic [2*PIXEL_BITS-1:0]    num_i,
  input  logic [PIXEL_BITS-1:0]      den_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [PIXEL_BITS-1:0]      intensity_out_o
);
  import csp_pkg::*;

  localparam int P  = PIXEL_BITS;
  localparam int CW = $clog2(P);
  localparam logic [P-1:0] MAXV = {P{1'b1}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [P-1:0]  rem_q, rem_d, nlo_q, nlo_d, dvs_q, dvs_d, quo_q, quo_d;
  logic          out_valid_q, out_valid_d;
  logic [P-1:0]  out_data_q, out_data_d;
  logic          out_free, is_div;
  logic [P:0]    trial;
  kind_e         kind;

  assign kind     = kind_e'(kind_i);
  assign is_div   = (kind == KIND_DIV);
  assign out_free = ~out_valid_q | out_ready_i;
  assign pop_o    = (state_q == S_IDLE) & entry_valid_i & (is_div | out_free);
  assign trial    = {rem_q, nlo_q[P-1]};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    nlo_d       = nlo_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          if (is_div) begin
            // The upper half is already below the divisor, so P steps suffice.
            rem_d   = num_i[2*P-1:P];
            nlo_d   = num_i[P-1:0];
            dvs_d   = den_i;
            quo_d   = '0;
            cnt_d   = '0;
            state_d = S_DIV;
          end else begin
            out_valid_d = 1'b1;
            out_data_d  = (kind == KIND_FULL) ? MAXV : '0;
          end
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = P'(trial - {1'b0, dvs_q});
          quo_d = {quo_q[P-2:0], 1'b1};
        end else begin
          rem_d = trial[P-1:0];
          quo_d = {quo_q[P-2:0], 1'b0};
        end
        nlo_d = {nlo_q[P-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(P - 1)) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = quo_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    nlo_q      <= nlo_d;
    dvs_q      <= dvs_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o     = out_valid_q;
  assign intensity_out_o = out_data_q;

endmodule

>>> rtl/contrast_stretch_pixel_top.sv
// Top level of the min/max contrast stretch block.
//
// Requests arrive on a valid/ready channel. A scan request (operation 0) folds
// max(red, green, blue) into the frame minimum and maximum; first_pixel restarts
// them. Scan requests are taken one per cycle and give no result. An apply
// request (operation 1) gives one stretched intensity on the output channel.
// The front end classifies each apply request in the cycle it is taken and
// puts it into a two-entry queue. Results that clamp to zero or full scale
// pass through the queue and the output register, at one per cycle while the
// receiver does not stall and no division is under way. Other results go
// through a serial restoring divider that yields one quotient bit a cycle;
// the back end takes no new entry until the quotient is in the output register.
// The contrast offset register is written through cfg_we_i and cfg_wdata_i.
// Reset sets the frame minimum to full scale, the maximum and the offset to
// zero, and empties the queue and the output register. When the receiver
// stalls, the result holds in the output register, the divider waits with its
// quotient, and the queue fills before apply requests are refused.
module contrast_stretch_pixel_top #(
  parameter int PIXEL_BITS = csp_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [csp_pkg::OFFSET_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         operation_i,
  input  logic                         first_pixel_i,
  input  logic [PIXEL_BITS-1:0]        red_i,
  input  logic [PIXEL_BITS-1:0]        green_i,
  input  logic [PIXEL_BITS-1:0]        blue_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [PIXEL_BITS-1:0]        intensity_out_o
);
  import csp_pkg::*;

  localparam int DW = KIND_W + 3 * PIXEL_BITS;

  logic                    fifo_full, push, pop, entry_valid;
  logic [KIND_W-1:0]       kind_f, kind_b;
  logic [2*PIXEL_BITS-1:0] num_f, num_b;
  logic [PIXEL_BITS-1:0]   den_f, den_b;
  logic [DW-1:0]           push_data, pop_data;

  csp_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .first_pixel_i (first_pixel_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .kind_o        (kind_f),
    .num_o         (num_f),
    .den_o         (den_f)
  );

  assign push_data = {kind_f, num_f, den_f};

  csp_fifo #(.DW(DW)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .valid_o     (entry_valid),
    .pop_data_o  (pop_data)
  );

  assign kind_b = pop_data[DW-1 -: KIND_W];
  assign num_b  = pop_data[PIXEL_BITS +: 2*PIXEL_BITS];
  assign den_b  = pop_data[PIXEL_BITS-1:0];

  csp_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_valid_i   (entry_valid),
    .kind_i          (kind_b),
    .num_i           (num_b),
    .den_i           (den_b),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .intensity_out_o (intensity_out_o)
  );

endmodule

>>> tb/contrast_stretch_pixel_top_tb.sv
// Self-checking testbench for the contrast stretch block: scan/apply pixel streams with offsets.
module contrast_stretch_pixel_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB           = csp_pkg::PIXEL_BITS_DEF;
  localparam int MAXV         = (1 << PB) - 1;
  localparam int OW           = csp_pkg::OFFSET_W;
  localparam logic OP_SCAN    = 1'b0;
  localparam logic OP_APPLY   = 1'b1;
  localparam int SETTLE_CYCLES = 2 * PB + 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS  = 134;

  typedef logic [PB-1:0] pix_t;

  typedef struct packed {
    logic apply;
    logic first;
    pix_t red;
    pix_t green;
    pix_t blue;
  } pixel_req_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [OW-1:0] cfg_wdata_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic          operation_i = OP_SCAN;
  logic          first_pixel_i = 1'b0;
  pix_t          red_i = '0;
  pix_t          green_i = '0;
  pix_t          blue_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  pix_t          intensity_out_o;

  contrast_stretch_pixel_top #(
    .PIXEL_BITS(PB)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .first_pixel_i  (first_pixel_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .intensity_out_o(intensity_out_o)
  );

  always #1 clk_i = ~clk_i;

  // Requests waiting to be driven and stretched intensities waiting to come out.
  pixel_req_t pending_reqs[$];
  int         stretch_expect_q[$];

  // Shadow of the frame statistics and the offset register.
  int frame_lo = MAXV;
  int frame_hi = 0;
  int stretch_offset = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int scan_count = 0;
  int apply_count = 0;
  int checked_count = 0;
  int offset_writes = 0;
  int stall_cycles = 0;

  function automatic int max3(int a, int b, int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic int stretched_intensity(int v);
    int lo, hi, num, den, q;
    lo = frame_lo;
    hi = frame_hi;
    if (stretch_offset > 0) begin
      lo = lo - stretch_offset;
      if (lo < 0) lo = 0;
      hi = hi + stretch_offset;
      if (hi > MAXV) hi = MAXV;
    end else if (stretch_offset < 0) begin
      lo = lo - stretch_offset;
      hi = hi - stretch_offset;
    end
    if (hi == lo) begin
      q = (v > lo) ? MAXV : 0;
    end else begin
      num = MAXV * (v - lo);
      den = hi - lo;
      q = num / den;
      // Division truncates toward zero; step down to get the floor.
      if ((num % den) != 0 && ((num < 0) != (den < 0))) q = q - 1;
      if (q < 0) q = 0;
      if (q > MAXV) q = MAXV;
    end
    return q;
  endfunction

  function automatic void predict_request(logic op, logic first, pix_t r, pix_t g, pix_t b);
    int v;
    v = max3(int'(r), int'(g), int'(b));
    if (op == OP_SCAN) begin
      scan_count++;
      if (first) begin
        frame_lo = v;
        frame_hi = v;
      end else begin
        if (v < frame_lo) frame_lo = v;
        if (v > frame_hi) frame_hi = v;
      end
    end else begin
      apply_count++;
      stretch_expect_q.push_back(stretched_intensity(v));
    end
  endfunction

  function automatic void queue_pixel(logic op, logic first, int r, int g, int b);
    pixel_req_t p;
    p.apply = op;
    p.first = first;
    p.red   = pix_t'(r);
    p.green = pix_t'(g);
    p.blue  = pix_t'(b);
    pending_reqs.push_back(p);
  endfunction

  // One component carries the intensity, the other two fall at or below it.
  function automatic void queue_shaped(logic op, logic first, int base, int spread);
    int v, k;
    v = base + $urandom_range(spread);
    if (v > MAXV) v = MAXV;
    k = $urandom_range(2);
    queue_pixel(op, first,
                (k == 0) ? v : $urandom_range(v),
                (k == 1) ? v : $urandom_range(v),
                (k == 2) ? v : $urandom_range(v));
  endfunction

  // Mostly whole frames (restart scan, scans, applies), with some noise mixed in.
  function automatic void queue_random_phase(int n_items);
    int added, n_scan, n_apply, base, spread, abase;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(99) < 15) begin
        queue_pixel(1'($urandom_range(1)), 1'($urandom_range(1)),
                    $urandom_range(MAXV), $urandom_range(MAXV), $urandom_range(MAXV));
        added++;
      end else begin
        case ($urandom_range(5))
          0:       spread = 0;
          1:       spread = $urandom_range(1, 3);
          2:       spread = $urandom_range(4, 40);
          5:       spread = MAXV;
          default: spread = $urandom_range(40, MAXV);
        endcase
        base = $urandom_range(MAXV - spread);
        n_scan = $urandom_range(1, 12);
        n_apply = $urandom_range(1, 10);
        // A frame now and then continues the previous statistics.
        queue_shaped(OP_SCAN, $urandom_range(7) != 0, base, spread);
        for (int i = 1; i < n_scan; i++) queue_shaped(OP_SCAN, 1'b0, base, spread);
        abase = (base > 10) ? base - 10 : 0;
        for (int i = 0; i < n_apply; i++)
          queue_shaped(OP_APPLY, 1'($urandom_range(1)), abase, spread + 20);
        added += n_scan + n_apply;
      end
    end
  endfunction

  task automatic write_offset(int off);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= off[OW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stretch_offset = off;
    offset_writes++;
  endtask

  // Waits for every request to go in and every result to come out, then lets the divider settle.
  task automatic drain_block();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || stretch_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_requests
    pixel_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_request(operation_i, first_pixel_i, red_i, green_i, blue_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_reqs.pop_front();
          in_valid_i    <= 1'b1;
          operation_i   <= req.apply;
          first_pixel_i <= req.first;
          red_i         <= req.red;
          green_i       <= req.green;
          blue_i        <= req.blue;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    int want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (stretch_expect_q.size() == 0) begin
          $error("intensity_out: result %0d arrived with none expected", intensity_out_o);
          fail_count++;
        end else begin
          want = stretch_expect_q.pop_front();
          checked_count++;
          if (intensity_out_o !== pix_t'(want)) begin
            $error("intensity_out: expected %0d, actual %0d", want, intensity_out_o);
            fail_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Ends the run if work is outstanding but nothing moves for too long.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni && (in_valid_i || pending_reqs.size() != 0 || stretch_expect_q.size() != 0)) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end else begin
      stall_cycles = 0;
    end
  end

  initial begin : run_regression
    int offset_plan[RANDOM_PHASES];
    offset_plan = '{255, -255, 0, 1, -1, 128, -128, 17, 0, 0, 0};
    for (int i = 8; i < RANDOM_PHASES; i++) offset_plan[i] = int'($urandom_range(510)) - 255;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 48;

    // Applies before any scan with a widening offset: the range comes out inverted.
    write_offset(40);
    queue_pixel(OP_APPLY, 1'b0, 0, 0, 0);
    queue_pixel(OP_APPLY, 1'b0, 128, 3, 90);
    queue_pixel(OP_APPLY, 1'b0, 0, 0, MAXV);
    drain_block();

    // Still no scan: minimum above maximum with no offset.
    write_offset(0);
    queue_pixel(OP_APPLY, 1'b0, 0, 0, 0);
    queue_pixel(OP_APPLY, 1'b1, 0, 128, 0);
    queue_pixel(OP_APPLY, 1'b0, MAXV, MAXV, MAXV);
    // A one-value frame gives an empty range; first_pixel on an apply must not restart it.
    queue_pixel(OP_SCAN, 1'b1, 100, 7, 99);
    queue_pixel(OP_APPLY, 1'b0, 100, 0, 0);
    queue_pixel(OP_APPLY, 1'b0, 0, 101, 0);
    queue_pixel(OP_APPLY, 1'b1, 0, 0, 99);
    queue_pixel(OP_APPLY, 1'b0, 100, 100, 100);
    // Full-scale frame, then the end points and the middle.
    queue_pixel(OP_SCAN, 1'b1, 0, 0, 0);
    queue_pixel(OP_SCAN, 1'b0, 0, MAXV, 0);
    queue_pixel(OP_APPLY, 1'b0, 0, 0, 0);
    queue_pixel(OP_APPLY, 1'b0, MAXV, 0, 0);
    queue_pixel(OP_APPLY, 1'b0, 0, 128, 127);
    queue_pixel(OP_APPLY, 1'b0, 1, 0, 0);
    queue_pixel(OP_APPLY, 1'b0, 0, 0, 254);
    drain_block();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 37;
        recv_idle_pct = 48;
      end else if (p < 8) begin
        send_idle_pct = 48;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_offset(offset_plan[p]);
      queue_random_phase(PHASE_ITEMS);
      drain_block();
    end

    $display("Run covered %0d scan and %0d apply requests under %0d offset settings.",
             scan_count, apply_count, offset_writes);
    $display("%0d stretched results were compared, %0d mismatches seen.",
             checked_count, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
